// File: rtl/core/ssp_pkg.sv
// Shared types, constants and helpers for the softclip score spreader.
`timescale 1ns / 1ps

package ssp_pkg;

    localparam int MAX_RADIUS_DEF = 64;
    localparam int SCORE_W = 16;
    localparam int CLIP_W = 8;
    localparam int ACC_W = 24;
    localparam int RADIUS_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [ACC_W-1:0] SAT24 = 24'hFFFFFF;
    localparam logic [ACC_W:0] ONE_Q16 = 25'd65536;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 7'd16;
    localparam logic [CLIP_W-1:0] TRIGGER_RST = 8'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS  = 2'd0,
        REG_TRIGGER = 2'd1,
        REG_SQUASH  = 2'd2,
        REG_NONE    = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPREAD,
        ST_DRAIN,
        ST_RD,
        ST_CALC,
        ST_DIV,
        ST_OUT
    } state_t;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [SCORE_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {{(ACC_W + 1 - SCORE_W){1'b0}}, b};
        return s[ACC_W] ? SAT24 : s[ACC_W-1:0];
    endfunction

endpackage

// File: rtl/core/softclip_score_spreader_unit.sv
// Softclip score spreader: delay-line accumulator with optional squash divide.
`timescale 1ns / 1ps

// Takes one score and clip count per transaction and returns one Q8.16 score,
// the accumulated value of the position pushed R steps earlier (R = radius
// clamped to 1..MAX_RADIUS), or a/(a+1-o) when squash is enabled. State sits
// in three simple dual-port memories (accumulator line, original scores,
// future addends) walked as circular buffers. Without spreading, an item passes
// through accept, read, update and output before the next acceptance; a
// triggering item first runs a read-modify-write sweep over both lines
// (r = min(clip_count, R)) and a drain, and squash adds the bit-serial
// divider. The output register lets a new item enter while the
// previous result waits.
module softclip_score_spreader_unit
    import ssp_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // [15:0] score, [23:16] clip_count
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [23:0] spread_score
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS) : 1;
    localparam int FD = MAX_RADIUS + 1;
    localparam int FAW = $clog2(FD);
    localparam int KW = $clog2(MAX_RADIUS + 1);
    localparam int SW = KW + 2;

    // configuration
    logic [RADIUS_W-1:0] radius_reg;
    logic [CLIP_W-1:0]   trigger_reg;
    logic                squash_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= RADIUS_RST;
            trigger_reg <= TRIGGER_RST;
            squash_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RADIUS:  radius_reg  <= cfg_data[RADIUS_W-1:0];
                REG_TRIGGER: trigger_reg <= cfg_data[CLIP_W-1:0];
                REG_SQUASH:  squash_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // memories
    logic [ACC_W-1:0]   acc_mem [MAX_RADIUS];
    logic [SCORE_W-1:0] org_mem [MAX_RADIUS];
    logic [ACC_W-1:0]   fut_mem [FD];
    logic [MAX_RADIUS-1:0] acc_vld_reg, org_vld_reg;
    logic [FD-1:0]         fut_vld_reg;

    logic [AW-1:0]  acc_ra, acc_wa, org_wa;
    logic [FAW-1:0] fut_ra, fut_wa;
    logic           acc_we, org_we, fut_we, fut_clr;
    logic [ACC_W-1:0]   acc_wd, fut_wd;
    logic [ACC_W-1:0]   acc_rd_reg, fut_rd_reg;
    logic [SCORE_W-1:0] org_rd_reg;
    logic               acc_rv_reg, fut_rv_reg, org_rv_reg;
    logic [ACC_W-1:0]   acc_rdata, fut_rdata;
    logic [SCORE_W-1:0] org_rdata;
    logic [SCORE_W-1:0] score_reg, score_next;

    always_ff @(posedge clk)
    begin
        if (acc_we)
            acc_mem[acc_wa] <= acc_wd;
        acc_rd_reg <= acc_mem[acc_ra];
    end

    always_ff @(posedge clk)
    begin
        if (org_we)
            org_mem[org_wa] <= score_reg;
        org_rd_reg <= org_mem[acc_ra];
    end

    always_ff @(posedge clk)
    begin
        if (fut_we)
            fut_mem[fut_wa] <= fut_wd;
        fut_rd_reg <= fut_mem[fut_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_vld_reg <= '0;
            org_vld_reg <= '0;
            fut_vld_reg <= '0;
            acc_rv_reg  <= 1'b0;
            org_rv_reg  <= 1'b0;
            fut_rv_reg  <= 1'b0;
        end
        else
        begin
            acc_rv_reg <= acc_vld_reg[acc_ra];
            org_rv_reg <= org_vld_reg[acc_ra];
            fut_rv_reg <= fut_vld_reg[fut_ra];
            if (acc_we)
                acc_vld_reg[acc_wa] <= 1'b1;
            if (org_we)
                org_vld_reg[org_wa] <= 1'b1;
            if (fut_we)
                fut_vld_reg[fut_wa] <= 1'b1;
            else if (fut_clr)
                fut_vld_reg[fut_wa] <= 1'b0;
        end
    end

    assign acc_rdata = acc_rv_reg ? acc_rd_reg : '0;
    assign org_rdata = org_rv_reg ? org_rd_reg : '0;
    assign fut_rdata = fut_rv_reg ? fut_rd_reg : '0;

    // control
    state_t state_reg, state_next;
    logic [KW-1:0]  rr_reg, rr_next, bigr_reg, bigr_next, k_reg, k_next;
    logic [AW-1:0]  wp_reg, wp_next;
    logic [FAW-1:0] fp_reg, fp_next;
    logic           pacc_reg, pacc_next, pfut_reg, pfut_next;
    logic [AW-1:0]  pacc_a_reg, pacc_a_next;
    logic [FAW-1:0] pfut_a_reg, pfut_a_next;
    logic [ACC_W:0]   den_reg, den_next, rem_reg, rem_next;
    logic [SCORE_W-1:0] q_reg, q_next;
    logic [3:0]     cnt_reg, cnt_next;
    logic [ACC_W-1:0] res_reg, res_next, out_reg, out_next;
    logic           out_vld_reg, out_vld_next;

    logic [SW-1:0]  acc_sw, fut_sw, leave_sw;
    logic [AW-1:0]  acc_sweep_a, leave_a;
    logic [FAW-1:0] fut_sweep_a;
    logic [KW-1:0]  eff_r, clip_r;
    logic [ACC_W+1:0] trial, diff;

    always_comb
    begin
        acc_sw = SW'(wp_reg) + SW'(MAX_RADIUS - 1) - SW'(k_reg);
        if (acc_sw >= SW'(MAX_RADIUS))
            acc_sw = acc_sw - SW'(MAX_RADIUS);
        acc_sweep_a = acc_sw[AW-1:0];
        fut_sw = SW'(fp_reg) + SW'(k_reg);
        if (fut_sw >= SW'(FD))
            fut_sw = fut_sw - SW'(FD);
        fut_sweep_a = fut_sw[FAW-1:0];
        leave_sw = SW'(wp_reg) + SW'(MAX_RADIUS) - SW'(bigr_reg);
        if (leave_sw >= SW'(MAX_RADIUS))
            leave_sw = leave_sw - SW'(MAX_RADIUS);
        leave_a = leave_sw[AW-1:0];
        if (radius_reg == '0)
            eff_r = KW'(1);
        else if (int'(radius_reg) > MAX_RADIUS)
            eff_r = KW'(MAX_RADIUS);
        else
            eff_r = KW'(radius_reg);
        if (int'(s_tdata[23:16]) < int'(eff_r))
            clip_r = KW'(s_tdata[23:16]);
        else
            clip_r = eff_r;
    end

    assign trial = {rem_reg, 1'b0};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        state_next   = state_reg;
        score_next   = score_reg;
        rr_next      = rr_reg;
        bigr_next    = bigr_reg;
        k_next       = k_reg;
        wp_next      = wp_reg;
        fp_next      = fp_reg;
        pacc_next    = 1'b0;
        pfut_next    = 1'b0;
        pacc_a_next  = pacc_a_reg;
        pfut_a_next  = pfut_a_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && !m_tready;
        s_tready     = 1'b0;
        acc_ra       = acc_sweep_a;
        fut_ra       = fut_sweep_a;
        // pending sweep writes land in the cycle after their read
        acc_we       = pacc_reg;
        acc_wa       = pacc_a_reg;
        acc_wd       = sat_add(acc_rdata, score_reg);
        fut_we       = pfut_reg;
        fut_wa       = pfut_a_reg;
        fut_wd       = sat_add(fut_rdata, score_reg);
        fut_clr      = 1'b0;
        org_we       = 1'b0;
        org_wa       = wp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    score_next = s_tdata[15:0];
                    bigr_next  = eff_r;
                    rr_next    = clip_r;
                    k_next     = '0;
                    state_next = (s_tdata[23:16] >= trigger_reg) ? ST_SPREAD : ST_RD;
                end
            end
            ST_SPREAD:
            begin
                pfut_next   = 1'b1;
                pfut_a_next = fut_sweep_a;
                pacc_next   = (k_reg < rr_reg);
                pacc_a_next = acc_sweep_a;
                if (k_reg == rr_reg)
                    state_next = ST_DRAIN;
                else
                    k_next = k_reg + KW'(1);
            end
            ST_DRAIN:
            begin
                state_next = ST_RD;
            end
            ST_RD:
            begin
                acc_ra     = leave_a;
                fut_ra     = fp_reg;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                acc_we  = 1'b1;
                acc_wa  = wp_reg;
                acc_wd  = sat_add(fut_rdata, score_reg);
                org_we  = 1'b1;
                fut_we  = 1'b0;
                fut_clr = 1'b1;
                fut_wa  = fp_reg;
                wp_next = (int'(wp_reg) == MAX_RADIUS - 1) ? '0 : wp_reg + AW'(1);
                fp_next = (int'(fp_reg) == FD - 1) ? '0 : fp_reg + FAW'(1);
                if (squash_reg)
                begin
                    rem_next   = {1'b0, acc_rdata};
                    den_next   = {1'b0, acc_rdata} + ONE_Q16
                                 - {{(ACC_W + 1 - SCORE_W){1'b0}}, org_rdata};
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    res_next   = acc_rdata;
                    state_next = ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = diff[ACC_W:0];
                    q_next   = {q_reg[SCORE_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[ACC_W:0];
                    q_next   = {q_reg[SCORE_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    res_next   = {{(ACC_W - SCORE_W){1'b0}}, q_next};
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_next     = res_reg;
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            wp_reg      <= '0;
            fp_reg      <= '0;
            pacc_reg    <= 1'b0;
            pfut_reg    <= 1'b0;
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            wp_reg      <= wp_next;
            fp_reg      <= fp_next;
            pacc_reg    <= pacc_next;
            pfut_reg    <= pfut_next;
            cnt_reg     <= cnt_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg  <= score_next;
        rr_reg     <= rr_next;
        bigr_reg   <= bigr_next;
        pacc_a_reg <= pacc_a_next;
        pfut_a_reg <= pfut_a_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

`ifndef SYNTH
    // partial remainder always stays below the divisor
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < den_reg)
        else $error("divider remainder not below divisor");

    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SPREAD |-> k_reg <= rr_reg && rr_reg <= bigr_reg)
        else $error("sweep index beyond spread window");

    a_calc_next: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CALC |=> state_reg == ST_DIV || state_reg == ST_OUT)
        else $error("bad transition after calc");

    a_no_write_collide: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD |-> !pacc_reg && !pfut_reg)
        else $error("sweep write still pending at final read");
`endif

endmodule

// File: tb/sv/tb_top.sv
// Testbench for the softclip score spreader: predicts each result and checks it.
`timescale 1ns / 1ps

class spread_scoreboard;
    logic [23:0] accum_q [64];
    logic [15:0] orig_q [64];
    logic [23:0] owed_q [65];
    logic [6:0] radius;
    logic [7:0] trigger;
    logic squash;
    logic [23:0] pending_q [$];
    int mismatches;

    function new();
        radius = 7'd16;
        trigger = 8'd4;
        squash = 1'b0;
        mismatches = 0;
        foreach (accum_q[k]) accum_q[k] = '0;
        foreach (orig_q[k]) orig_q[k] = '0;
        foreach (owed_q[k]) owed_q[k] = '0;
    endfunction

    function logic [23:0] add_sat(logic [23:0] a, logic [15:0] b);
        logic [24:0] s;
        s = {1'b0, a} + 25'(b);
        return s[24] ? 24'hFFFFFF : s[23:0];
    endfunction

    function void write_reg(ssp_pkg::cfg_reg_t idx, logic [7:0] val);
        case (idx)
            ssp_pkg::REG_RADIUS:  radius = val[6:0];
            ssp_pkg::REG_TRIGGER: trigger = val;
            ssp_pkg::REG_SQUASH:  squash = val[0];
            default: ;
        endcase
    endfunction

    function void note_item(logic [15:0] score, logic [7:0] clips);
        int eff, r;
        logic [23:0] own, leaving, res;
        logic [15:0] orig_old;
        logic [47:0] num, den;
        eff = (radius < 1) ? 1 : (radius > 64 ? 64 : int'(radius));
        if (clips >= trigger) begin
            r = (clips < eff) ? int'(clips) : eff;
            for (int k = 0; k < r; k++) accum_q[k] = add_sat(accum_q[k], score);
            for (int k = 0; k <= r; k++) owed_q[k] = add_sat(owed_q[k], score);
        end
        own = add_sat(owed_q[0], score);
        for (int k = 0; k < 64; k++) owed_q[k] = owed_q[k+1];
        owed_q[64] = '0;
        leaving = accum_q[eff-1];
        orig_old = orig_q[eff-1];
        for (int k = 63; k > 0; k--)
        begin
            accum_q[k] = accum_q[k-1];
            orig_q[k] = orig_q[k-1];
        end
        accum_q[0] = own;
        orig_q[0] = score;
        if (squash)
        begin
            num = 48'(leaving) << 16;
            den = 48'(leaving) + 48'd65536 - 48'(orig_old);
            res = 24'(num / den);
        end
        else
            res = leaving;
        pending_q.insert(pending_q.size(), res);
    endfunction

    function void check_result(logic [23:0] got);
        logic [23:0] want;
        if (pending_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending_q.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("spread_score: expected %h, got %h", want, got);
        end
    endfunction
endclass

module tb_top;
    import ssp_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [23:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_NONE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    spread_scoreboard board = new();
    bit quiet_phase = 1'b0;
    bit hold_sink = 1'b0;
    int idle_cycles = 0;

    softclip_score_spreader_unit DUT (.*);

    always #10 clk = ~clk;

    // check on the edge where the result transaction completes
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) board.check_result(m_tdata);
        if (rst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("softclip_score_spreader_unit: mismatch");
            $finish;
        end
    end

    // receiver with random stall bursts
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_sink)
                m_tready <= 1'b0;
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 7);
                m_tready <= 1'b0;
                repeat (n - 1) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // valid stays up between back-to-back items; it drops only for idle gaps
    task automatic send_item(logic [15:0] score, logic [7:0] clips);
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {clips, score};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_item(score, clips);
    endtask

    task automatic write_cfg(cfg_reg_t idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending_q.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic random_items(int n, int clip_max);
        logic [15:0] sc;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0: sc = 16'hFFFF;
                1: sc = 16'($urandom_range(0, 255));
                default: sc = 16'($urandom);
            endcase
            send_item(sc, 8'($urandom_range(0, clip_max)));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: field extremes, trigger threshold edges
        send_item(16'h0000, 8'd0);
        send_item(16'hFFFF, 8'd255);
        send_item(16'hFFFF, 8'd3);
        send_item(16'hFFFF, 8'd4);
        send_item(16'h5555, 8'hAA);
        send_item(16'hAAAA, 8'h55);
        for (int i = 0; i < 12; i++) send_item(16'hFFFF, 8'd200);
        wait_drained();
        // zero threshold with zero clips, squash on
        write_cfg(REG_TRIGGER, 8'd0);
        write_cfg(REG_SQUASH, 8'd1);
        for (int i = 0; i < 6; i++) send_item(16'hFFFF, 8'd0);
        wait_drained();
        // radius out of range both ways
        write_cfg(REG_RADIUS, 8'd0);
        send_item(16'h1234, 8'd9);
        send_item(16'hFFFF, 8'd1);
        wait_drained();
        write_cfg(REG_RADIUS, 8'd127);
        write_cfg(REG_SQUASH, 8'd0);
        random_items(40, 255);
        wait_drained();
        // long receiver stall while the sender keeps offering
        fork
        begin
            hold_sink = 1'b1;
            repeat (400) @(posedge clk);
            hold_sink = 1'b0;
        end
        random_items(60, 8);
        join
        wait_drained();
        for (int ph = 0; ph < 8; ph++)
        begin
            write_cfg(REG_RADIUS, 8'(ph == 0 ? 1 : (ph == 1 ? 64 : $urandom_range(1, 20))));
            write_cfg(REG_TRIGGER, 8'(ph == 2 ? 255 : $urandom_range(0, 10)));
            write_cfg(REG_SQUASH, 8'($urandom_range(0, 1)));
            // the radius changes between runs while the stored line state is kept
            random_items(140, ph == 1 ? 80 : 24);
            wait_drained();
        end
        quiet_phase = 1'b1;
        random_items(100, 24);
        wait_drained();
        if (board.mismatches == 0 && board.pending_q.size() == 0)
            $display("softclip_score_spreader_unit: match");
        else
            $display("softclip_score_spreader_unit: mismatch");
        $finish;
    end
endmodule

// File: files.f
rtl/core/ssp_pkg.sv
rtl/core/softclip_score_spreader_unit.sv
tb/sv/tb_top.sv
